>>> rtl/core/lrit_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrit_pkg
// Shared types and constants for the longest run insert tracker.
// ----------------------------------------------------------------------------
package lrit_pkg;

   localparam int POSITIONS = 1024;
   localparam int POS_W     = $clog2(POSITIONS);
   localparam int LEN_W     = POS_W + 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_MERGE,
      ST_WR_LO,
      ST_WR_HI,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic read_right;
      logic take_left;
      logic write_self;
      logic write_lo;
      logic write_hi;
      logic clear_write;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic self_built;
      logic clear_last;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/core/lrit_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrit_ctrl
// Sequencer: table clear after reset, neighbor reads, merge writes, response.
// ----------------------------------------------------------------------------
module lrit_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  lrit_pkg::status_type    status,
   output lrit_pkg::cmd_type       cmd
);

   lrit_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrit_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lrit_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = lrit_pkg::ST_IDLE;
         end
         lrit_pkg::ST_IDLE: begin
            if (req_valid) state_in = lrit_pkg::ST_LOOK;
         end
         lrit_pkg::ST_LOOK: begin
            if (status.self_built) state_in = lrit_pkg::ST_DONE;
            else                   state_in = lrit_pkg::ST_MERGE;
         end
         lrit_pkg::ST_MERGE: state_in = lrit_pkg::ST_WR_LO;
         lrit_pkg::ST_WR_LO: state_in = lrit_pkg::ST_WR_HI;
         lrit_pkg::ST_WR_HI: state_in = lrit_pkg::ST_DONE;
         lrit_pkg::ST_DONE: begin
            if (status.rsp_free) state_in = lrit_pkg::ST_IDLE;
         end
         default: state_in = lrit_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         lrit_pkg::ST_CLEAR: cmd.clear_write = 1'b1;
         lrit_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         lrit_pkg::ST_LOOK: begin
            cmd.take_left  = 1'b1;
            cmd.read_right = 1'b1;
         end
         lrit_pkg::ST_MERGE: cmd.write_self = 1'b1;
         lrit_pkg::ST_WR_LO: cmd.write_lo   = 1'b1;
         lrit_pkg::ST_WR_HI: cmd.write_hi   = 1'b1;
         lrit_pkg::ST_DONE:  cmd.load_rsp   = status.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/core/lrit_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrit_dp
// Run length table memory, neighbor registers, merge arithmetic, best run
// and response register.
// ----------------------------------------------------------------------------
module lrit_dp (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire  [lrit_pkg::POS_W-1:0]           req_position,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [lrit_pkg::LEN_W-1:0]           rsp_longest_run,
   input  lrit_pkg::cmd_type                    cmd,
   output lrit_pkg::status_type                 status
);

   localparam int PW = lrit_pkg::POS_W;
   localparam int LW = lrit_pkg::LEN_W;

   logic [LW-1:0] mem [lrit_pkg::POSITIONS];

   logic [PW-1:0] pos_ff;
   logic [PW-1:0] clr_cnt_ff;
   logic [LW-1:0] rd_a_ff, rd_b_ff;
   logic [LW-1:0] left_ff;
   logic [LW-1:0] merged_ff;
   logic [LW:0]   lo_ff, hi_ff;
   logic [LW-1:0] best_ff;
   logic          rsp_valid_ff;
   logic [LW-1:0] rsp_run_ff;

   logic [PW-1:0] rd_a_addr, rd_b_addr;
   logic [LW-1:0] right;
   logic [LW:0]   merged_sum, lo_wide, hi_wide;
   logic          lo_ok, hi_ok;
   logic          wr_en;
   logic [PW-1:0] wr_addr;
   logic [LW-1:0] wr_data;

   assign rd_a_addr = cmd.read_right ? pos_ff + 1'b1 : req_position;
   assign rd_b_addr = req_position - 1'b1;

   assign right = (pos_ff == PW'(lrit_pkg::POSITIONS - 1)) ? '0 : rd_a_ff;
   assign merged_sum = {1'b0, left_ff} + (LW+1)'(1) + {1'b0, right};
   assign lo_wide    = (LW+1)'(pos_ff) - {1'b0, left_ff};
   assign hi_wide    = (LW+1)'(pos_ff) + {1'b0, right};
   assign lo_ok      = !lo_ff[LW];
   assign hi_ok      = hi_ff < (LW+1)'(lrit_pkg::POSITIONS);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = merged_sum[LW-1:0];
      priority if (cmd.clear_write) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else if (cmd.write_self) begin
         wr_en   = 1'b1;
      end else if (cmd.write_lo) begin
         wr_en   = lo_ok;
         wr_addr = lo_ff[PW-1:0];
         wr_data = merged_ff;
      end else if (cmd.write_hi) begin
         wr_en   = hi_ok;
         wr_addr = hi_ff[PW-1:0];
         wr_data = merged_ff;
      end else begin
         wr_en   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) pos_ff <= req_position;
      if (cmd.take_left) left_ff <= (pos_ff == '0) ? '0 : rd_b_ff;
      if (cmd.write_self) begin
         merged_ff <= merged_sum[LW-1:0];
         lo_ff     <= lo_wide;
         hi_ff     <= hi_wide;
      end
      if (cmd.load_rsp) rsp_run_ff <= best_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_write) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (cmd.write_lo && merged_ff > best_ff) best_ff <= merged_ff;
         if (cmd.load_rsp)      rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)   rsp_valid_ff <= 1'b0;
      end
   end

   assign status.self_built = rd_a_ff != '0;
   assign status.clear_last = clr_cnt_ff == PW'(lrit_pkg::POSITIONS - 1);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_longest_run = rsp_run_ff;

endmodule
`default_nettype wire

>>> rtl/core/longest_run_insert_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// longest_run_insert_tracker
// Marks one slot per beat as built and returns the longest built run so far.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 1024-entry run length table to zero, one
// entry a cycle, and holds req_stall high until the sweep is done. Each beat
// then takes one slot index; the response is the longest contiguous run of
// built slots after that beat. A new slot goes through these steps: accept
// with the self and left-neighbor reads, right-neighbor read, then three
// single-port writes at the slot and at both ends of the merged run, then the
// response load; a slot already built skips the writes. The table's one
// write port orders the writes. The response sits in an output register,
// so the next beat is accepted while a response is still stalled.
// ----------------------------------------------------------------------------
module longest_run_insert_tracker (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [lrit_pkg::POS_W-1:0]           req_position,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [lrit_pkg::LEN_W-1:0]           rsp_longest_run
);

   lrit_pkg::cmd_type    cmd;
   lrit_pkg::status_type status;

   lrit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lrit_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_longest_run (rsp_longest_run),
      .cmd             (cmd),
      .status          (status)
   );

endmodule
`default_nettype wire

>>> tb/tb_longest_run_insert_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_run_insert_tracker
// Self-checking bench for the longest run insert tracker.
// ----------------------------------------------------------------------------
// Slot indexes go in on the req channel and longest-run answers come back on
// the rsp channel. A scoreboard keeps its own run length table and best run,
// works out the answer for every accepted slot and compares answers in order.
// A short directed list covers the table edges, repeats and merges from the
// left, the right and both sides. Random slots follow, mostly next to recent
// ones so that runs grow and join. Both sides idle at random, there is one
// calm stretch, and once the receiver holds off long enough to back up input.
// ----------------------------------------------------------------------------
module tb_longest_run_insert_tracker;

   localparam int POSITIONS = lrit_pkg::POSITIONS;
   localparam int POS_W     = lrit_pkg::POS_W;
   localparam int LEN_W     = lrit_pkg::LEN_W;

   localparam int RANDOM_ITEMS  = 800;
   localparam int PRESSURE_HOLD = 400;
   localparam int MAX_REPORTS   = 10;

   class run_scoreboard;
      logic [LEN_W-1:0] run_len [POSITIONS];
      logic [LEN_W-1:0] best_len;
      logic [LEN_W-1:0] expected_runs [$];
      int               mismatches;

      function new();
         foreach (run_len[i]) run_len[i] = '0;
         best_len   = '0;
         mismatches = 0;
      endfunction

      function void note_position(logic [POS_W-1:0] pos);
         int p;
         int left;
         int right;
         int merged;
         p = int'(pos);
         if (run_len[p] == 0) begin
            left   = (p > 0) ? int'(run_len[p-1]) : 0;
            right  = (p < POSITIONS - 1) ? int'(run_len[p+1]) : 0;
            merged = left + 1 + right;
            if (left <= p) run_len[p-left] = LEN_W'(merged);
            if (p + right < POSITIONS) run_len[p+right] = LEN_W'(merged);
            run_len[p] = LEN_W'(merged);
            if (merged > int'(best_len)) best_len = LEN_W'(merged);
         end
         expected_runs = {expected_runs, best_len};
      endfunction

      function void check_run(logic [LEN_W-1:0] got);
         logic [LEN_W-1:0] want;
         if (expected_runs.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: response %0d with no beat outstanding", $realtime, got);
         end else begin
            want = expected_runs.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: longest_run expected %0d got %0d", $realtime, want, got);
            end
         end
      endfunction

      function int pending();
         return expected_runs.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [POS_W-1:0] req_position;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [LEN_W-1:0] rsp_longest_run;

   run_scoreboard sb;
   bit            calm;
   bit            hold_request;

   longest_run_insert_tracker dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_longest_run (rsp_longest_run)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("FAIL longest_run_insert_tracker");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_position(req_position);
         if (rsp_valid && !rsp_stall) sb.check_run(rsp_longest_run);
      end
   end

   // sink side: random stall stretches, one long hold on request
   initial begin
      int len;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            len = PRESSURE_HOLD;
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            len = pick_gap() + 1;
         end else begin
            rsp_stall <= 1'b0;
            len = $urandom_range(1, 8);
         end
         repeat (len - 1) @(negedge clock);
      end
   end

   task automatic send_position(input logic [POS_W-1:0] pos);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_position <= pos;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   initial begin
      logic [POS_W-1:0] directed [$];
      logic [POS_W-1:0] last_pos;
      logic [POS_W-1:0] pos;
      int               r;
      int               step;
      int               burst;

      sb           = new();
      calm         = 1'b0;
      hold_request = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_position = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // edges, repeats, right/left/both-side joins, long chain join
      directed = '{10'd0, 10'd1023, 10'd0, 10'd1022, 10'd1021, 10'd1, 10'd5, 10'd7,
                   10'd6, 10'd6, 10'd3, 10'd4, 10'd2, 10'd512, 10'd511, 10'd513,
                   10'd1020, 10'd8, 10'd1023, 10'd9};
      foreach (directed[i]) send_position(directed[i]);

      last_pos = 10'd300;
      burst    = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 300 && n < 380);
         if (n == 120) hold_request = 1'b1;
         if (burst > 0) begin
            pos = last_pos + 1'b1;
            burst--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
               pos = POS_W'($urandom_range(0, POSITIONS - 1));
            end else if (r < 75) begin
               step = $urandom_range(1, 3);
               pos  = $urandom_range(0, 1) ? POS_W'(int'(last_pos) + step)
                                           : POS_W'(int'(last_pos) - step);
            end else if (r < 85) begin
               pos = last_pos;
            end else begin
               pos   = POS_W'($urandom_range(0, POSITIONS - 1));
               burst = $urandom_range(4, 24);
            end
         end
         send_position(pos);
         last_pos = pos;
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS longest_run_insert_tracker");
      end else begin
         $display("FAIL longest_run_insert_tracker");
      end
      $finish;
   end

endmodule
